@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Every check runs on clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define DRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The condition must never be true.
`define DRQ_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ design/drq_pkg.sv @@
// ----------------------------------------------------------------------------
// drq_pkg
// Shared types and constants of the damage rectangle queue.
// ----------------------------------------------------------------------------
package drq_pkg;

  // Draw results buffered per process item
  parameter int MAX_RESULTS = 64;
  parameter int RES_AW      = 6;   // result buffer address bits
  parameter int RES_CW      = 7;   // result count bits, holds MAX_RESULTS
  parameter int BUDGET_W    = 31;
  parameter int COUNT_W     = 6;

  // Function codes
  parameter logic FUNC_ADD  = 1'b0;
  parameter logic FUNC_PROC = 1'b1;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_HRD   = 15'h0002,  // head entry read back
    ST_HMUL  = 15'h0004,  // old pixel count, divider start
    ST_HDIV  = 15'h0008,  // strip rows of widened head
    ST_SRD   = 15'h0010,  // scan: issue read / append
    ST_SCHK  = 15'h0020,  // scan: compare widget / merge
    ST_PRD   = 15'h0040,  // drain: read head
    ST_PCHK  = 15'h0080,  // drain: rows in budget, divider start
    ST_PDIV  = 15'h0100,
    ST_PMUL  = 15'h0200,
    ST_PEMIT = 15'h0400,
    ST_FIN   = 15'h0800,
    ST_PLRD  = 15'h1000,  // playback: read result buffer
    ST_PLLD  = 15'h2000,  // playback: load output register
    ST_OUT   = 15'h4000
  } drq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/drq_ram.sv @@
// ----------------------------------------------------------------------------
// drq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module drq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/drq_div.sv @@
// ----------------------------------------------------------------------------
// drq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drq_div #(
  parameter int NW = 33,
  parameter int DW = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NW-1:0]            dividend_i,
  input  logic [DW-1:0]            divisor_i,
  output logic [NW-1:0]            quotient_o,
  output drq_pkg::div_stat_t       stat_o
);
  import drq_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_q, q_d;
  logic [DW-1:0]   r_q, r_d;
  logic [DW-1:0]   d_q, d_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  always_comb begin
    trial  = {r_q, q_q[NW-1]};
    ge     = (trial >= {1'b0, d_q});
    diff   = trial - {1'b0, d_q};
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      q_d   = {q_q[NW-2:0], ge};
      r_d   = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign quotient_o  = q_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ design/damage_rect_queue.sv @@
// ----------------------------------------------------------------------------
// damage_rect_queue
// Ring queue of per-widget redraw rectangles with a budgeted row drain.
// ----------------------------------------------------------------------------
// One item at a time. An add item with an empty rectangle changes nothing;
// else it compares the head entry, then later queue entries in turn, for a
// matching widget and merges into the first match, or appends at the tail;
// a match at the head uses the shared bit-serial divider to keep a strip of
// rows there and scans on with the rest. An add item gives one result. A
// process item runs the shared divider and an entry RAM read per drawn
// piece, then plays out its buffered draw results. All results of a process
// item carry the queue count after the whole drain, so draws are collected in
// a 64-entry result RAM and played out once the drain is over. Queue entries
// live in one entry RAM; head and tail indices are flops. Entries that were
// never written are never used, so no clearing pass is needed after reset.
// in_stall_o is high from acceptance until the last result has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module damage_rect_queue #(
  parameter int QUEUE_DEPTH     = 64,
  parameter int COORD_WIDTH     = 16,
  parameter int WIDGET_ID_WIDTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic [WIDGET_ID_WIDTH-1:0]         widget_id_i,
  input  logic signed [COORD_WIDTH-1:0]      left_i,
  input  logic signed [COORD_WIDTH-1:0]      top_i,
  input  logic signed [COORD_WIDTH-1:0]      right_i,
  input  logic signed [COORD_WIDTH-1:0]      bottom_i,
  input  logic [drq_pkg::BUDGET_W-1:0]       pixel_budget_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               draw_valid_o,
  output logic [WIDGET_ID_WIDTH-1:0]         draw_owner_o,
  output logic signed [COORD_WIDTH-1:0]      draw_x_o,
  output logic signed [COORD_WIDTH-1:0]      draw_y_o,
  output logic [COORD_WIDTH:0]               draw_width_o,
  output logic [COORD_WIDTH:0]               draw_height_o,
  output logic [drq_pkg::BUDGET_W-1:0]       drawn_pixels_o,
  output logic [drq_pkg::COUNT_W-1:0]        queued_count_o,
  output logic                               dropped_o,
  output logic                               last_o
);
  import drq_pkg::*;

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = COORD_WIDTH;
  localparam int BW  = COORD_WIDTH + 1;      // widths, heights, stored bottom
  localparam int XW  = COORD_WIDTH + 2;      // signed scratch width
  localparam int WW  = WIDGET_ID_WIDTH;
  localparam int DVW = (2 * COORD_WIDTH + 1 > BUDGET_W) ? 2 * COORD_WIDTH + 1 : BUDGET_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [WW-1:0]        wid;
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] top;
    logic signed [CW-1:0] right;
    logic signed [BW-1:0] bottom;   // one bit wider: empty strip fits
  } entry_t;

  typedef struct packed {
    logic [WW-1:0]        wid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [BW-1:0]        w;
    logic [BW-1:0]        h;
    logic [BUDGET_W-1:0]  pix;
  } res_t;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    nxt = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // control state
  drq_state_e        state_q, state_d;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [RES_CW-1:0] n_q, n_d, k_q, k_d;
  logic              last_q, last_d;

  // item and work registers
  logic [WW-1:0]        wid_q, wid_d;
  logic signed [CW-1:0] left_q, left_d, top_q, top_d;
  logic signed [CW-1:0] right_q, right_d, bottom_q, bottom_d;
  logic                 drop_q, drop_d;
  logic [BUDGET_W-1:0]  budget_q, budget_d, total_q, total_d, pix_q, pix_d;
  logic signed [CW-1:0] mx1_q, mx1_d, my1_q, my1_d, mx2_q, mx2_d;
  logic signed [BW-1:0] my2_q, my2_d;
  logic [BW-1:0]        oldw_q, oldw_d, oldh_q, oldh_d, neww_q, neww_d;
  logic [BW-1:0]        w_q, w_d, ht_q, ht_d, cutc_q, cutc_d;
  entry_t               ent_q, ent_d;

  // output payload registers
  logic                 odv_q, odv_d, odrop_q, odrop_d;
  res_t                 ores_q, ores_d;

  // RAM ports
  logic    e_we, e_re;
  logic [AW-1:0] e_waddr, e_raddr;
  entry_t  e_wdata, e_rd;
  logic    r_we, r_re;
  logic [RES_AW-1:0] r_waddr, r_raddr;
  res_t    r_wdata, r_rd;

  // divider
  logic            div_start;
  logic [DVW-1:0]  div_a, quot;
  logic [BW-1:0]   div_b;
  div_stat_t       div_stat;

  // queue occupancy
  logic [AW:0]  cnt;
  logic [31:0]  cnt_ext;
  logic         q_empty, q_full;
  logic         in_accept, out_accept;

  // scratch arithmetic
  logic signed [XW-1:0] s_a, s_b, s_c, s_sum;
  logic [2*BW-1:0]      prod;
  logic [BW-1:0]        cut;

  assign cnt = (tail_q >= head_q) ? ({1'b0, tail_q} - {1'b0, head_q})
                                  : ({1'b0, tail_q} + (AW + 1)'(QUEUE_DEPTH) - {1'b0, head_q});
  assign cnt_ext = 32'(cnt);
  assign q_empty = (head_q == tail_q);
  assign q_full  = (cnt >= (AW + 1)'(QUEUE_DEPTH - 1));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_accept  = out_valid_o && !out_stall_i;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cur_d    = cur_q;
    n_d      = n_q;
    k_d      = k_q;
    last_d   = last_q;
    wid_d    = wid_q;
    left_d   = left_q;
    top_d    = top_q;
    right_d  = right_q;
    bottom_d = bottom_q;
    drop_d   = drop_q;
    budget_d = budget_q;
    total_d  = total_q;
    pix_d    = pix_q;
    mx1_d    = mx1_q;
    my1_d    = my1_q;
    mx2_d    = mx2_q;
    my2_d    = my2_q;
    oldw_d   = oldw_q;
    oldh_d   = oldh_q;
    neww_d   = neww_q;
    w_d      = w_q;
    ht_d     = ht_q;
    cutc_d   = cutc_q;
    ent_d    = ent_q;
    odv_d    = odv_q;
    odrop_d  = odrop_q;
    ores_d   = ores_q;
    e_we     = 1'b0;
    e_waddr  = head_q;
    e_wdata  = e_rd;
    e_re     = 1'b0;
    e_raddr  = head_q;
    r_we     = 1'b0;
    r_waddr  = n_q[RES_AW-1:0];
    r_wdata  = '0;
    r_re     = 1'b0;
    r_raddr  = k_q[RES_AW-1:0];
    div_start = 1'b0;
    div_a    = '0;
    div_b    = '0;
    s_a      = '0;
    s_b      = '0;
    s_c      = '0;
    s_sum    = '0;
    prod     = '0;
    cut      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          e_re     = 1'b1;   // head entry, used by a non-empty add
          wid_d    = widget_id_i;
          left_d   = left_i;
          top_d    = top_i;
          right_d  = right_i;
          bottom_d = bottom_i;
          budget_d = pixel_budget_i;
          total_d  = '0;
          n_d      = '0;
          k_d      = '0;
          drop_d   = 1'b0;
          if (func_i == FUNC_PROC) begin
            state_d = ST_PRD;
          end else if (left_i > right_i || top_i > bottom_i) begin
            state_d = ST_FIN;  // empty rectangle: no change
          end else if (q_empty) begin
            cur_d   = head_q;
            state_d = ST_SRD;
          end else begin
            state_d = ST_HRD;
          end
        end
      end

      ST_HRD: begin
        if (e_rd.wid == wid_q) begin
          // bounding box of head and new rectangle
          mx1_d  = (left_q < e_rd.left)  ? left_q  : e_rd.left;
          my1_d  = (top_q < e_rd.top)    ? top_q   : e_rd.top;
          mx2_d  = (right_q > e_rd.right) ? right_q : e_rd.right;
          my2_d  = (BW'(bottom_q) > e_rd.bottom) ? BW'(bottom_q) : e_rd.bottom;
          s_a    = XW'(e_rd.right) - XW'(e_rd.left) + XW'(1);
          oldw_d = s_a[BW-1:0];
          s_b    = XW'(e_rd.bottom) - XW'(e_rd.top) + XW'(1);
          oldh_d = s_b[BW-1:0];
          s_c    = XW'(mx2_d) - XW'(mx1_d) + XW'(1);
          neww_d = s_c[BW-1:0];
          state_d = ST_HMUL;
        end else begin
          cur_d   = nxt(head_q);
          state_d = ST_SRD;
        end
      end

      ST_HMUL: begin
        prod      = oldw_q * oldh_q;
        div_start = 1'b1;
        div_a     = DVW'(prod);
        div_b     = neww_q;
        state_d   = ST_HDIV;
      end

      ST_HDIV: begin
        if (div_stat.done) begin
          // head keeps a top strip of whole rows worth its old pixel count
          cut     = quot[BW-1:0];
          s_a     = XW'(my1_q);
          s_b     = XW'(cut);
          s_sum   = s_a + s_b;
          s_c     = s_sum - XW'(1);
          e_we    = 1'b1;
          e_waddr = head_q;
          e_wdata = '{wid: wid_q, left: mx1_q, top: my1_q, right: mx2_q,
                      bottom: s_c[BW-1:0]};
          if (s_sum > XW'(my2_q)) begin
            state_d = ST_FIN;   // nothing left below the strip
          end else begin
            left_d   = mx1_q;
            right_d  = mx2_q;
            top_d    = s_sum[CW-1:0];
            bottom_d = my2_q[CW-1:0];
            cur_d    = nxt(head_q);
            state_d  = ST_SRD;
          end
        end
      end

      ST_SRD: begin
        if (cur_q == tail_q) begin
          if (q_full) begin
            drop_d = 1'b1;
          end else begin
            e_we    = 1'b1;
            e_waddr = tail_q;
            e_wdata = '{wid: wid_q, left: left_q, top: top_q, right: right_q,
                        bottom: BW'(bottom_q)};
            tail_d  = nxt(tail_q);
          end
          state_d = ST_FIN;
        end else begin
          e_re    = 1'b1;
          e_raddr = cur_q;
          state_d = ST_SCHK;
        end
      end

      ST_SCHK: begin
        if (e_rd.wid == wid_q) begin
          e_we    = 1'b1;
          e_waddr = cur_q;
          e_wdata = '{wid: wid_q,
                      left: (left_q < e_rd.left) ? left_q : e_rd.left,
                      top: (top_q < e_rd.top) ? top_q : e_rd.top,
                      right: (right_q > e_rd.right) ? right_q : e_rd.right,
                      bottom: (BW'(bottom_q) > e_rd.bottom) ? BW'(bottom_q)
                                                            : e_rd.bottom};
          state_d = ST_FIN;
        end else begin
          cur_d   = nxt(cur_q);
          state_d = ST_SRD;
        end
      end

      ST_PRD: begin
        if (q_empty || budget_q == '0 || n_q == RES_CW'(MAX_RESULTS)) begin
          state_d = ST_FIN;
        end else begin
          e_re    = 1'b1;
          e_raddr = head_q;
          state_d = ST_PCHK;
        end
      end

      ST_PCHK: begin
        ent_d     = e_rd;
        s_a       = XW'(e_rd.right) - XW'(e_rd.left) + XW'(1);
        s_b       = XW'(e_rd.bottom) - XW'(e_rd.top) + XW'(1);
        w_d       = s_a[BW-1:0];
        ht_d      = s_b[BW-1:0];
        div_start = 1'b1;
        div_a     = DVW'(budget_q);
        div_b     = s_a[BW-1:0];
        state_d   = ST_PDIV;
      end

      ST_PDIV: begin
        if (div_stat.done) begin
          if (quot == '0) begin
            state_d = ST_FIN;   // budget below one row
          end else begin
            cut    = (quot > DVW'(ht_q)) ? ht_q : quot[BW-1:0];
            cutc_d = cut;
            if (cut == '0) begin
              head_d  = nxt(head_q);   // empty strip: drop without drawing
              state_d = ST_PRD;
            end else begin
              state_d = ST_PMUL;
            end
          end
        end
      end

      ST_PMUL: begin
        prod    = w_q * cutc_q;
        pix_d   = BUDGET_W'(prod);
        state_d = ST_PEMIT;
      end

      ST_PEMIT: begin
        budget_d = budget_q - pix_q;
        total_d  = total_q + pix_q;
        r_we     = 1'b1;
        r_waddr  = n_q[RES_AW-1:0];
        r_wdata  = '{wid: ent_q.wid, x: ent_q.left, y: ent_q.top, w: w_q, h: cutc_q,
                     pix: total_q + pix_q};
        n_d      = n_q + 1'b1;
        if (cutc_q >= ht_q) begin
          head_d = nxt(head_q);
        end else begin
          s_a     = XW'(ent_q.top);
          s_b     = XW'(cutc_q);
          s_sum   = s_a + s_b;
          e_we    = 1'b1;
          e_waddr = head_q;
          e_wdata = ent_q;
          e_wdata.top = s_sum[CW-1:0];
        end
        state_d = ST_PRD;
      end

      ST_FIN: begin
        if (n_q == '0) begin
          odv_d   = 1'b0;
          ores_d  = '0;
          odrop_d = drop_q;
          last_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          k_d     = '0;
          state_d = ST_PLRD;
        end
      end

      ST_PLRD: begin
        r_re    = 1'b1;
        r_raddr = k_q[RES_AW-1:0];
        state_d = ST_PLLD;
      end

      ST_PLLD: begin
        odv_d   = 1'b1;
        ores_d  = r_rd;
        odrop_d = 1'b0;
        last_d  = (k_q + 1'b1 == n_q);
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (out_accept) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_PLRD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cur_q   <= '0;
      n_q     <= '0;
      k_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cur_q   <= cur_d;
      n_q     <= n_d;
      k_q     <= k_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wid_q    <= wid_d;
    left_q   <= left_d;
    top_q    <= top_d;
    right_q  <= right_d;
    bottom_q <= bottom_d;
    drop_q   <= drop_d;
    budget_q <= budget_d;
    total_q  <= total_d;
    pix_q    <= pix_d;
    mx1_q    <= mx1_d;
    my1_q    <= my1_d;
    mx2_q    <= mx2_d;
    my2_q    <= my2_d;
    oldw_q   <= oldw_d;
    oldh_q   <= oldh_d;
    neww_q   <= neww_d;
    w_q      <= w_d;
    ht_q     <= ht_d;
    cutc_q   <= cutc_d;
    ent_q    <= ent_d;
    odv_q    <= odv_d;
    odrop_q  <= odrop_d;
    ores_q   <= ores_d;
  end

  drq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (e_we),
    .wr_addr_i (e_waddr),
    .wr_data_i (e_wdata),
    .rd_en_i   (e_re),
    .rd_addr_i (e_raddr),
    .rd_data_o (e_rd)
  );

  drq_ram #(
    .WIDTH ($bits(res_t)),
    .DEPTH (MAX_RESULTS)
  ) u_res_ram (
    .clk_i     (clk_i),
    .wr_en_i   (r_we),
    .wr_addr_i (r_waddr),
    .wr_data_i (r_wdata),
    .rd_en_i   (r_re),
    .rd_addr_i (r_raddr),
    .rd_data_o (r_rd)
  );

  drq_div #(
    .NW (DVW),
    .DW (BW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quotient_o (quot),
    .stat_o     (div_stat)
  );

  assign draw_valid_o   = odv_q;
  assign draw_owner_o   = ores_q.wid;
  assign draw_x_o       = ores_q.x;
  assign draw_y_o       = ores_q.y;
  assign draw_width_o   = ores_q.w;
  assign draw_height_o  = ores_q.h;
  assign drawn_pixels_o = ores_q.pix;
  assign queued_count_o = cnt_ext[COUNT_W-1:0];
  assign dropped_o      = odrop_q;
  assign last_o         = last_q;

  `DRQ_ASSERT(a_out_holds_in, out_valid_o |-> in_stall_o, "input open with result pending")
  `DRQ_ASSERT(a_div_done_ctx, div_stat.done |-> (state_q == ST_HDIV || state_q == ST_PDIV), "divider done out of context")
  `DRQ_NEVER(a_res_overflow, n_q > RES_CW'(MAX_RESULTS), "result buffer overflow")

endmodule
